// ----- rtl/srt_pkg.sv -----
// Package for the shortest-remaining-time scheduler: sizes, codes, the slot
// entry type and the sort key. Used by every file in rtl.
// No dependencies.
package srt_pkg;

    localparam int SLOTS  = 16;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ID_W   = 8;
    localparam int TIME_W = 16;
    localparam int STAT_W = 3;
    localparam int KEY_W  = TIME_W + ID_W + SLOT_W;

    localparam logic CMD_ARRIVE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_IDLE   = 3'd0,
        ST_RAN    = 3'd1,
        ST_DONE   = 3'd2,
        ST_ACCEPT = 3'd3,
        ST_FULL   = 3'd4,
        ST_ZERO   = 3'd5
    } t_status;

    // One job as held by a cell. The slot number only breaks ties between
    // jobs with equal remaining time and equal id.
    typedef struct packed {
        logic [TIME_W-1:0] remaining;
        logic [ID_W-1:0]   job;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] arrival;
    } t_entry;

    typedef struct packed {
        logic insert;
        logic remove;
        logic dec;
    } t_cell_ctl;

    function automatic logic [KEY_W-1:0] entry_key(input t_entry e);
        return {e.remaining, e.job, e.slot};
    endfunction

endpackage

// ----- rtl/srt_if.sv -----
// Handshake interfaces for the scheduler's event and result channels.
// Depends on srt_pkg.
interface srt_in_if import srt_pkg::*;;
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [ID_W-1:0]   job_id;
    logic [TIME_W-1:0] service_time;

    modport source (output valid, cmd, job_id, service_time, input ready);
    modport sink   (input valid, cmd, job_id, service_time, output ready);
endinterface

interface srt_out_if import srt_pkg::*;;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   running_id;
    logic [TIME_W-1:0] remaining_after;
    logic [TIME_W-1:0] finish_time;
    logic [TIME_W-1:0] turnaround;

    modport source (output valid, status, running_id, remaining_after, finish_time,
                    turnaround, input ready);
    modport sink   (input valid, status, running_id, remaining_after, finish_time,
                    turnaround, output ready);
endinterface

// ----- rtl/shortest_remaining_time_scheduler.sv -----
// Top level of the shortest-remaining-time scheduler: a sorted row of cells,
// the slot map, the time counter and the result register.
// Depends on srt_pkg, srt_if and srt_cell.
//
//  channel  direction  payload                                          transfer when
//  i_in     sink       cmd, job_id, service_time                        valid && ready
//  o_out    source     status, running_id, remaining_after,
//                      finish_time, turnaround                          valid && ready
//
// Each event is handled in the cycle it is transferred; its result appears in
// the result register in the cycle after.
// The cells keep jobs sorted, so the next job to run is always in the first cell
// and an arrival is placed by one compare in every cell at once.
// A pending result that is not taken holds off new events.
// Synchronous reset empties the row, the slot map and the time counter.
module shortest_remaining_time_scheduler import srt_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    srt_in_if.sink          i_in,
    srt_out_if.source       o_out
);

    logic              c_valid [SLOTS];
    t_entry            c_entry [SLOTS];
    logic              c_lt    [SLOTS];
    t_cell_ctl         c_ctl   [SLOTS];

    logic [SLOTS-1:0]  r_used;
    logic [SLOTS-1:0]  n_used;
    logic [TIME_W-1:0] r_time;
    logic [TIME_W-1:0] n_time;

    logic              r_out_valid;
    logic              n_out_valid;
    t_status           r_status;
    t_status           n_status;
    logic [ID_W-1:0]   r_run_id;
    logic [ID_W-1:0]   n_run_id;
    logic [TIME_W-1:0] r_rem;
    logic [TIME_W-1:0] n_rem;
    logic [TIME_W-1:0] r_fin;
    logic [TIME_W-1:0] n_fin;
    logic [TIME_W-1:0] r_ta;
    logic [TIME_W-1:0] n_ta;

    logic              accept;
    logic              do_insert;
    logic              do_remove;
    logic              do_dec;
    logic [SLOT_W-1:0] free_slot;
    logic [TIME_W-1:0] head_rem;
    logic [TIME_W-1:0] fin_time;
    t_entry            new_entry;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    // Lowest free slot.
    always_comb begin
        free_slot = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_slot = SLOT_W'(i);
            end
        end
    end

    assign new_entry.remaining = i_in.service_time;
    assign new_entry.job       = i_in.job_id;
    assign new_entry.slot      = free_slot;
    assign new_entry.arrival   = r_time;

    assign head_rem = c_entry[0].remaining - TIME_W'(1);
    assign fin_time = r_time + TIME_W'(1);

    always_comb begin
        do_insert   = 1'b0;
        do_remove   = 1'b0;
        do_dec      = 1'b0;
        n_used      = r_used;
        n_time      = r_time;
        n_out_valid = r_out_valid && !o_out.ready;
        n_status    = r_status;
        n_run_id    = r_run_id;
        n_rem       = r_rem;
        n_fin       = r_fin;
        n_ta        = r_ta;
        if (accept) begin
            n_out_valid = 1'b1;
            n_run_id    = i_in.job_id;
            n_rem       = '0;
            n_fin       = '0;
            n_ta        = '0;
            if (i_in.cmd == CMD_TICK) begin
                n_time = fin_time;
                if (!c_valid[0]) begin
                    n_status = ST_IDLE;
                    n_run_id = '0;
                end else if (head_rem == '0) begin
                    // The first cell leaves the row and frees its slot.
                    do_remove                 = 1'b1;
                    n_used[c_entry[0].slot]   = 1'b0;
                    n_status                  = ST_DONE;
                    n_run_id                  = c_entry[0].job;
                    n_fin                     = fin_time;
                    n_ta                      = fin_time - c_entry[0].arrival;
                end else begin
                    do_dec   = 1'b1;
                    n_status = ST_RAN;
                    n_run_id = c_entry[0].job;
                    n_rem    = head_rem;
                end
            end else begin
                priority if (i_in.service_time == '0) begin
                    n_status = ST_ZERO;
                end else if (c_valid[SLOTS-1]) begin
                    n_status = ST_FULL;
                end else begin
                    do_insert         = 1'b1;
                    n_used[free_slot] = 1'b1;
                    n_status          = ST_ACCEPT;
                end
            end
        end
    end

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        logic   prev_valid;
        t_entry prev_entry;
        logic   prev_lt;
        logic   next_valid;
        t_entry next_entry;

        if (g == 0) begin : g_first
            assign prev_valid = 1'b0;
            assign prev_entry = new_entry;
            assign prev_lt    = 1'b1;
        end else begin : g_mid
            assign prev_valid = c_valid[g-1];
            assign prev_entry = c_entry[g-1];
            assign prev_lt    = c_lt[g-1];
        end

        if (g == SLOTS - 1) begin : g_last
            assign next_valid = 1'b0;
            assign next_entry = '0;
        end else begin : g_inner
            assign next_valid = c_valid[g+1];
            assign next_entry = c_entry[g+1];
        end

        assign c_ctl[g].insert = do_insert;
        assign c_ctl[g].remove = do_remove;
        assign c_ctl[g].dec    = (g == 0) ? do_dec : 1'b0;

        srt_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_prev_valid (prev_valid),
            .i_prev       (prev_entry),
            .i_prev_lt    (prev_lt),
            .i_next_valid (next_valid),
            .i_next       (next_entry),
            .i_new        (new_entry),
            .i_ctl        (c_ctl[g]),
            .o_valid      (c_valid[g]),
            .o_entry      (c_entry[g]),
            .o_lt         (c_lt[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_time      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_used      <= n_used;
            r_time      <= n_time;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_run_id <= n_run_id;
        r_rem    <= n_rem;
        r_fin    <= n_fin;
        r_ta     <= n_ta;
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_status;
    assign o_out.running_id      = r_run_id;
    assign o_out.remaining_after = r_rem;
    assign o_out.finish_time     = r_fin;
    assign o_out.turnaround      = r_ta;

endmodule

// ----- rtl/srt_cell.sv -----
// One cell of the sorted job row. Cells are kept ordered by key, valid ones
// first; a cell takes a value from itself, its neighbors or the new job.
// Depends on srt_pkg.
module srt_cell import srt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_prev_valid,
    input  t_entry    i_prev,
    input  logic      i_prev_lt,
    input  logic      i_next_valid,
    input  t_entry    i_next,
    input  t_entry    i_new,
    input  t_cell_ctl i_ctl,
    output logic      o_valid,
    output t_entry    o_entry,
    output logic      o_lt
);

    logic   r_valid;
    logic   n_valid;
    t_entry r_entry;
    t_entry n_entry;

    assign o_valid = r_valid;
    assign o_entry = r_entry;
    // Invalid cells sort after everything.
    assign o_lt    = r_valid && (entry_key(r_entry) < entry_key(i_new));

    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        priority if (i_ctl.remove) begin
            n_valid = i_next_valid;
            n_entry = i_next;
        end else if (i_ctl.insert) begin
            if (!o_lt) begin
                if (i_prev_lt) begin
                    n_valid = 1'b1;
                    n_entry = i_new;
                end else begin
                    n_valid = i_prev_valid;
                    n_entry = i_prev;
                end
            end
        end else if (i_ctl.dec) begin
            n_entry.remaining = r_entry.remaining - TIME_W'(1);
        end else begin
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ----- rtl/srt_checker.sv -----
// Port-level checks for the scheduler, attached to the top level by bind.
// Depends on srt_pkg and shortest_remaining_time_scheduler.
module srt_checker import srt_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [STAT_W-1:0] i_status,
    input logic [TIME_W-1:0] i_rem,
    input logic [TIME_W-1:0] i_fin,
    input logic [TIME_W-1:0] i_ta
);

    // A stalled result must stay on the port.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // Every transferred event produces a result on the next cycle.
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid)
        else $error("event without result");

    // No event is taken while a result waits and the sink is stalled.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("event taken over a pending result");

    // Finish time and turnaround are reported only for a finished job.
    a_fin_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != ST_DONE) |-> (i_fin == '0) && (i_ta == '0))
        else $error("finish data on a result that did not finish");

    // A job that ran without finishing still has time left.
    a_ran_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_RAN) |-> (i_rem != '0))
        else $error("running job reported with no time left");

endmodule

bind shortest_remaining_time_scheduler srt_checker u_srt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_status    (o_out.status),
    .i_rem       (o_out.remaining_after),
    .i_fin       (o_out.finish_time),
    .i_ta        (o_out.turnaround)
);

// ----- bench/srt_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the shortest-remaining-time scheduler: tracks the job table,
// predicts each report and compares it with what the block returns.
// Depends on srt_pkg and srt_if.
module srt_scoreboard import srt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    srt_in_if    i_events,
    srt_out_if   i_results,
    output int   o_errors,
    output int   o_pending,
    output int   o_checked,
    output int   o_finished
);

    typedef struct packed {
        t_status           status;
        logic [ID_W-1:0]   job;
        logic [TIME_W-1:0] remaining;
        logic [TIME_W-1:0] finish;
        logic [TIME_W-1:0] turnaround;
    } t_report;

    logic              slot_busy  [SLOTS];
    logic [TIME_W-1:0] slot_left  [SLOTS];
    logic [ID_W-1:0]   slot_owner [SLOTS];
    logic [TIME_W-1:0] slot_stamp [SLOTS];
    logic [TIME_W-1:0] clock_now;

    t_report report_q[$];

    // Applies one event to the job table and returns the report it causes.
    function automatic t_report schedule_event(input logic cmd, input logic [ID_W-1:0] id,
                                               input logic [TIME_W-1:0] svc);
        t_report           r;
        int                pick;
        logic [TIME_W-1:0] fin;
        r = '0;
        r.status = ST_IDLE;
        pick = -1;
        if (cmd == CMD_ARRIVE) begin
            r.job = id;
            if (svc == '0) begin
                r.status = ST_ZERO;
            end else begin
                for (int i = 0; i < SLOTS; i++)
                    if (!slot_busy[i] && pick < 0) pick = i;
                if (pick < 0) begin
                    r.status = ST_FULL;
                end else begin
                    slot_busy[pick]  = 1'b1;
                    slot_owner[pick] = id;
                    slot_left[pick]  = svc;
                    slot_stamp[pick] = clock_now;
                    r.status = ST_ACCEPT;
                end
            end
        end else begin
            // Least remaining time wins, then the lower id, then the lower slot.
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_busy[i] && (pick < 0 || slot_left[i] < slot_left[pick] ||
                    (slot_left[i] == slot_left[pick] && slot_owner[i] < slot_owner[pick])))
                    pick = i;
            end
            if (pick >= 0) begin
                slot_left[pick] = slot_left[pick] - 1'b1;
                r.job = slot_owner[pick];
                if (slot_left[pick] == '0) begin
                    fin = clock_now + 1'b1;
                    r.status     = ST_DONE;
                    r.finish     = fin;
                    r.turnaround = fin - slot_stamp[pick];
                    slot_busy[pick] = 1'b0;
                end else begin
                    r.status    = ST_RAN;
                    r.remaining = slot_left[pick];
                end
            end
            clock_now = clock_now + 1'b1;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_report want;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) slot_busy[i] = 1'b0;
            clock_now = '0;
            report_q.delete();
            o_errors   = 0;
            o_checked  = 0;
            o_finished = 0;
        end else begin
            if (i_events.valid && i_events.ready)
                report_q = {report_q, schedule_event(i_events.cmd, i_events.job_id,
                                                     i_events.service_time)};
            if (i_results.valid && i_results.ready) begin
                if (report_q.size() == 0) begin
                    o_errors++;
                    $display("%0t: report with nothing expected: status %0d id %0d",
                             $time, i_results.status, i_results.running_id);
                end else begin
                    want = report_q.pop_front();
                    o_checked++;
                    if (want.status == ST_DONE) o_finished++;
                    if (i_results.status !== want.status ||
                        i_results.running_id !== want.job ||
                        i_results.remaining_after !== want.remaining ||
                        i_results.finish_time !== want.finish ||
                        i_results.turnaround !== want.turnaround) begin
                        o_errors++;
                        $display({"%0t: mismatch: expected status %0d id %0d rem %0d ",
                                  "fin %0d ta %0d, got status %0d id %0d rem %0d ",
                                  "fin %0d ta %0d"}, $time,
                                 want.status, want.job, want.remaining, want.finish,
                                 want.turnaround, i_results.status,
                                 i_results.running_id, i_results.remaining_after,
                                 i_results.finish_time, i_results.turnaround);
                    end
                end
            end
        end
        o_pending = report_q.size();
    end

endmodule

// ----- bench/shortest_remaining_time_scheduler_tb.sv -----
`timescale 1ns / 100ps
// Top of the scheduler testbench: clock, reset, event stimulus and result
// back-pressure around the block, with srt_scoreboard doing the scoring.
// Depends on srt_pkg, srt_if, srt_scoreboard and the scheduler RTL.
module shortest_remaining_time_scheduler_tb;
    import srt_pkg::*;

    localparam int PHASE_ITEMS = 150;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_LIMIT = 5000;
    localparam int SETTLE      = 10;
    // Enough ticks to run every job left by the directed part, the longest
    // one included.
    localparam int RUNOUT_TICKS = 80;

    logic i_clk;
    logic i_rst_n;

    srt_in_if  ev_bus ();
    srt_out_if res_bus ();

    int idle_pct     = 0;
    int stall_pct    = 0;
    int arrive_share = 50;
    int hold_req     = 0;
    int hold_done    = 0;
    int hold_left    = 0;
    int errors, pending, checked, finished;

    shortest_remaining_time_scheduler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (ev_bus),
        .o_out   (res_bus)
    );

    srt_scoreboard u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_events   (ev_bus),
        .i_results  (res_bus),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_checked  (checked),
        .o_finished (finished)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("shortest_remaining_time_scheduler_tb failed");
        $finish;
    end

    // Result side: random stalls, plus a long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            res_bus.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_done) begin
            res_bus.ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= hold_req;
        end else begin
            res_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Starts and ends at a falling edge; returns once the event is transferred.
    task automatic drive_event(input logic cmd, input logic [ID_W-1:0] id,
                               input logic [TIME_W-1:0] svc);
        while ($urandom_range(0, 99) < idle_pct) begin
            ev_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        ev_bus.valid        <= 1'b1;
        ev_bus.cmd          <= cmd;
        ev_bus.job_id       <= id;
        ev_bus.service_time <= svc;
        @(posedge i_clk);
        while (!ev_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Mostly short jobs so the table keeps turning over; a few zero-length
    // arrivals and a few very long jobs.
    task automatic random_event(input int share);
        logic [31:0]       rnd;
        logic              cmd;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] svc;
        int                pick;
        rnd = $urandom;
        id  = rnd[7:0];
        svc = rnd[31:16];
        cmd = CMD_TICK;
        if ($urandom_range(0, 99) < share) begin
            cmd  = CMD_ARRIVE;
            pick = $urandom_range(0, 199);
            if (pick < 8)
                svc = '0;
            else if (pick >= 27)
                svc = 16'($urandom_range(1, 4));
            else if (pick >= 11)
                svc = 16'($urandom_range(5, 30));
        end
        drive_event(cmd, id, svc);
    endtask

    task automatic wait_drained;
        int spins;
        spins = 0;
        while (pending != 0 && spins < DRAIN_LIMIT) begin
            @(negedge i_clk);
            spins++;
        end
    endtask

    initial begin
        logic [31:0] rnd;
        ev_bus.valid        = 1'b0;
        ev_bus.cmd          = CMD_TICK;
        ev_bus.job_id       = '0;
        ev_bus.service_time = '0;
        res_bus.ready       = 1'b0;
        i_rst_n             = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Idle tick, zero-length job, a job that finishes on its first tick.
        drive_event(CMD_TICK, 8'h00, 16'h0000);
        drive_event(CMD_ARRIVE, 8'hFF, 16'h0000);
        drive_event(CMD_ARRIVE, 8'h00, 16'h0001);
        drive_event(CMD_TICK, 8'h00, 16'h0000);
        // Two jobs with the same id and time: the lower slot must win.
        drive_event(CMD_ARRIVE, 8'h07, 16'h0003);
        drive_event(CMD_ARRIVE, 8'h07, 16'h0003);
        drive_event(CMD_ARRIVE, 8'hFF, 16'h0014);
        repeat (3) drive_event(CMD_TICK, 8'h00, 16'h0000);
        // Fill the table, then overflow it; a zero-length job on a full
        // table is still rejected as zero-length.
        repeat (14) begin
            rnd = $urandom;
            drive_event(CMD_ARRIVE, rnd[7:0], 16'($urandom_range(1, 4)));
        end
        drive_event(CMD_ARRIVE, 8'h42, 16'h0005);
        drive_event(CMD_ARRIVE, 8'h43, 16'h0000);

        // Run everything out, including the longest job.
        repeat (RUNOUT_TICKS) random_event(0);

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 52; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 52; end
                default: begin idle_pct = 28; stall_pct = 28; end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k % 32 == 0) arrive_share = $urandom_range(10, 55);
                // Hold results back while events keep coming, so the block
                // stalls its input.
                if (p == 0 && k == 60) hold_req++;
                random_event(arrive_share);
            end
            if (p == 1) begin
                ev_bus.valid <= 1'b0;
                wait_drained();
            end
        end

        ev_bus.valid <= 1'b0;
        wait_drained();
        repeat (SETTLE) @(negedge i_clk);

        $display("Checked %0d reports with %0d job completions, idle ticks, zero and full",
                 checked, finished);
        $display("rejections, duplicate ids, gaps, stalls and a hold-off.");
        if (errors == 0 && pending == 0)
            $display("shortest_remaining_time_scheduler_tb passed");
        else
            $display("shortest_remaining_time_scheduler_tb failed");
        $finish;
    end

endmodule
